// ----- hw/rtl/gwgs_pkg.sv -----
// Shared types and constants of the Gerstner wave grid sum block.
package gwgs_pkg;

  // Action codes of an input request
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIM_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COUNT  = 2'd3;
  localparam int CFG_DATA_W = 32;

  // Position divider: index (10b) * length (16b) * 256
  localparam int DIV_W  = 34;
  localparam int DIVC_W = $clog2(DIV_W);
  localparam int POS_W  = 36;
  // Angle bits kept: turn index sits in bits 41..26
  localparam int ANG_W  = 42;

  // Polynomial sine coefficients
  localparam int SIN_K1 = 102944;
  localparam int SIN_K3 = 42047;
  localparam int SIN_K5 = 4640;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [17:0] SIN_CLIP = 18'd65536;

  // One wave component as stored in the table
  typedef struct packed {
    logic [15:0] amp;
    logic [15:0] kspat;
    logic [15:0] ktemp;
    logic [15:0] phase;
    logic [15:0] hx;
    logic [15:0] hy;
    logic [15:0] steep;
  } wave_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PREP = 13'b0000000000010,
    S_DIV  = 13'b0000000000100,
    S_READ = 13'b0000000001000,
    S_MUL  = 13'b0000000010000,
    S_DOT  = 13'b0000000100000,
    S_ANG  = 13'b0000001000000,
    S_SQ   = 13'b0000010000000,
    S_P1   = 13'b0000100000000,
    S_P2   = 13'b0001000000000,
    S_SIN  = 13'b0010000000000,
    S_ACC  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

endpackage

// ----- hw/rtl/gerstner_wave_grid_sum.sv -----
// Gerstner wave grid sum: wave table, position divider, sine unit and accumulators.
//
// Usage: an input request with action load writes one wave component into
// the table slot wave_slot (slots at or beyond MAX_WAVES are dropped) and
// gives no result. An evaluate request names grid point (grid_x, grid_y) and
// gives one result: height, shift_x, shift_y, summed over the first
// wave_count table entries and saturated to signed Q8.8.
// Channels: in_valid/in_stall and out_valid/out_stall; a request moves at a
// clock edge with valid high and stall low. Configuration is written through
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data, by the user
// only while idle; the block itself does not enforce this. A load is written
// into the table when taken. An evaluate runs two position divisions, each a
// prepare step and then one quotient bit per cycle in a shared restoring
// divider, then for each summed wave a table read, products, three polynomial
// steps and an accumulate (wave_count clamped to MAX_WAVES), then the output
// register; no new request is taken until the block is back in idle.
// The output register holds a finished result while the receiver stalls; the
// block takes the next request meanwhile and waits only to hand over the next
// result. Reset clears control state and loads the register defaults; the
// wave table holds no defined contents until loaded.
module gerstner_wave_grid_sum
  import gwgs_pkg::*;
#(
  parameter int MAX_WAVES = 8,
  parameter int MAX_GRID  = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [2:0]            wave_slot,
  input  logic [15:0]           amplitude,
  input  logic [15:0]           spatial_freq,
  input  logic [15:0]           temporal_freq,
  input  logic [15:0]           phase_turns,
  input  logic signed [15:0]    heading_x,
  input  logic signed [15:0]    heading_y,
  input  logic [15:0]           steepness,
  input  logic [9:0]            grid_x,
  input  logic [9:0]            grid_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    height,
  output logic signed [15:0]    shift_x,
  output logic signed [15:0]    shift_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
  localparam int CNTB = $clog2(MAX_WAVES + 1);
  localparam int NW   = $clog2(MAX_GRID + 1);
  localparam int HSW  = 35 + CNTB;
  localparam int XSW  = 51 + CNTB;

  // Configuration registers
  logic [10:0] grid_size;
  logic [15:0] grid_length;
  logic [31:0] sim_time;
  logic [3:0]  wave_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size   <= 11'd256;
      grid_length <= 16'd25600;
      sim_time    <= 32'd0;
      wave_count  <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_SIZE:   grid_size   <= cfg_data[10:0];
        CFG_GRID_LENGTH: grid_length <= cfg_data[15:0];
        CFG_SIM_TIME:    sim_time    <= cfg_data;
        CFG_WAVE_COUNT:  wave_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size and wave count to what the hardware holds
  logic [NW-1:0]   n_eff;
  logic [CNTB-1:0] count;

  always_comb begin
    if (grid_size == 11'd0) begin
      n_eff = NW'(1);
    end else if (32'(grid_size) > MAX_GRID) begin
      n_eff = NW'(MAX_GRID);
    end else begin
      n_eff = NW'(grid_size);
    end
    if (32'(wave_count) > MAX_WAVES) begin
      count = CNTB'(MAX_WAVES);
    end else begin
      count = CNTB'(wave_count);
    end
  end

  state_t state;

  logic in_acc;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Wave table memory, one component per entry
  wave_t           mem [MAX_WAVES];
  wave_t           rd_data;
  wave_t           wr_data;
  logic            mem_we;
  logic            mem_re;
  logic [CNTB-1:0] wi;

  assign mem_we = in_acc && (action == ACT_LOAD) && (32'(wave_slot) < MAX_WAVES);
  assign mem_re = (state == S_READ);
  assign wr_data = '{amp: amplitude, kspat: spatial_freq, ktemp: temporal_freq,
                     phase: phase_turns, hx: heading_x, hy: heading_y,
                     steep: steepness};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(wave_slot)] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[wi[AW-1:0]];
    end
  end

  // Restoring divider for the grid position, one quotient bit per cycle
  logic              axis;
  logic [DIVC_W-1:0] div_cnt;
  logic [NW-1:0]     div_rem;
  logic [DIV_W-1:0]  div_quo;
  logic [9:0]        gx;
  logic [9:0]        gy;
  logic [25:0]       idx_len;
  logic [NW:0]       rem_sh;
  logic [NW+1:0]     rem_diff;
  logic              q_bit;
  logic [DIV_W-1:0]  q_final;
  logic signed [POS_W-1:0] pos_c;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;

  always_comb begin
    idx_len  = 26'(axis ? gy : gx) * 26'(grid_length);
    rem_sh   = {div_rem, div_quo[DIV_W-1]};
    rem_diff = {1'b0, rem_sh} - {2'b00, n_eff};
    q_bit    = ~rem_diff[NW+1];
    q_final  = {div_quo[DIV_W-2:0], q_bit};
    pos_c    = signed'({2'b00, q_final}) - signed'({13'd0, grid_length, 7'd0});
  end

  // Per-wave datapath registers
  logic signed [ANG_W-1:0] m_hx;
  logic signed [ANG_W-1:0] m_hy;
  logic [27:0]             wt;
  logic [15:0]             qa;
  logic [ANG_W-1:0]        dot;
  logic signed [32:0]      hq_x;
  logic signed [32:0]      hq_y;
  logic [15:0]             ang_a;
  logic [ANG_W-1:0]        kd;
  logic [ANG_W-1:0]        ang_sum;
  logic [31:0]             sq_amp;

  always_comb begin
    kd      = ANG_W'(rd_data.kspat) * dot;
    ang_sum = kd - {wt, 14'd0} + {rd_data.phase, 26'd0};
    sq_amp  = 32'(rd_data.steep) * 32'(rd_data.amp);
  end

  // Sine lanes: lane 0 gives sin(a), lane 1 gives cos(a) = sin(a + quarter turn)
  logic [1:0]         l_quad [2];
  logic [14:0]        l_r    [2];
  logic [14:0]        l_x2   [2];
  logic [15:0]        l_u1   [2];
  logic [16:0]        l_u2   [2];
  logic signed [17:0] l_s    [2];

  logic [15:0]        lane_ang [2];
  logic [14:0]        r_c      [2];
  logic [29:0]        sq_c     [2];
  logic [27:0]        t1_c     [2];
  logic [30:0]        t2_c     [2];
  logic [31:0]        t3_c     [2];
  logic [17:0]        mag_c    [2];
  logic [15:0]        u1_c     [2];
  logic [16:0]        u2_c     [2];
  logic signed [17:0] s_c      [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lane_ang[l] = ang_a + ((l == 1) ? QUARTER_TURN : 16'd0);
      if (lane_ang[l][14]) begin
        r_c[l] = 15'(15'd16384 - {1'b0, lane_ang[l][13:0]});
      end else begin
        r_c[l] = {1'b0, lane_ang[l][13:0]};
      end
      sq_c[l] = 30'(r_c[l]) * 30'(r_c[l]);
      t1_c[l] = 28'(l_x2[l]) * 28'(SIN_K5);
      u1_c[l] = 16'(SIN_K3 - int'(t1_c[l][27:14]));
      t2_c[l] = 31'(l_u1[l]) * 31'(l_x2[l]);
      u2_c[l] = 17'(SIN_K1 - int'(t2_c[l][30:14]));
      t3_c[l] = 32'(l_u2[l]) * 32'(l_r[l]);
      mag_c[l] = (t3_c[l][31:14] > SIN_CLIP) ? SIN_CLIP : t3_c[l][31:14];
      s_c[l] = l_quad[l][1] ? -signed'(mag_c[l]) : signed'(mag_c[l]);
    end
  end

  // Accumulation terms
  logic signed [34:0]    h_term;
  logic signed [50:0]    x_term;
  logic signed [50:0]    y_term;
  logic signed [HSW-1:0] hsum;
  logic signed [XSW-1:0] xsum;
  logic signed [XSW-1:0] ysum;

  always_comb begin
    h_term = 35'(signed'({1'b0, rd_data.amp})) * 35'(l_s[1]);
    x_term = 51'(hq_x) * 51'(l_s[0]);
    y_term = 51'(hq_y) * 51'(l_s[0]);
  end

  // Round half up and saturate to Q8.8
  logic signed [HSW-17:0] h_rnd;
  logic signed [XSW-31:0] x_rnd;
  logic signed [XSW-31:0] y_rnd;
  logic signed [15:0]     h_sat;
  logic signed [15:0]     x_sat;
  logic signed [15:0]     y_sat;
  logic signed [HSW-1:0]  h_bias;
  logic signed [XSW-1:0]  x_bias;
  logic signed [XSW-1:0]  y_bias;

  always_comb begin
    h_bias = hsum + HSW'(1 << 15);
    x_bias = xsum + XSW'(64'sd1 << 29);
    y_bias = ysum + XSW'(64'sd1 << 29);
    h_rnd  = h_bias[HSW-1:16];
    x_rnd  = x_bias[XSW-1:30];
    y_rnd  = y_bias[XSW-1:30];
    if (h_rnd > (HSW-16)'(32767)) begin
      h_sat = 16'sh7fff;
    end else if (h_rnd < (HSW-16)'(-32768)) begin
      h_sat = -16'sh8000;
    end else begin
      h_sat = 16'(h_rnd);
    end
    if (x_rnd > (XSW-30)'(32767)) begin
      x_sat = 16'sh7fff;
    end else if (x_rnd < (XSW-30)'(-32768)) begin
      x_sat = -16'sh8000;
    end else begin
      x_sat = 16'(x_rnd);
    end
    if (y_rnd > (XSW-30)'(32767)) begin
      y_sat = 16'sh7fff;
    end else if (y_rnd < (XSW-30)'(-32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = 16'(y_rnd);
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Sequencer: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= 1'b0;
      div_cnt <= '0;
      wi      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (action == ACT_EVAL)) begin
            axis  <= 1'b0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (32'(div_cnt) == DIV_W - 1) begin
            if (!axis) begin
              axis  <= 1'b1;
              state <= S_PREP;
            end else begin
              wi    <= '0;
              state <= (count == '0) ? S_DONE : S_READ;
            end
          end
        end
        S_READ: state <= S_MUL;
        S_MUL:  state <= S_DOT;
        S_DOT:  state <= S_ANG;
        S_ANG:  state <= S_SQ;
        S_SQ:   state <= S_P1;
        S_P1:   state <= S_P2;
        S_P2:   state <= S_SIN;
        S_SIN:  state <= S_ACC;
        S_ACC: begin
          // advance to the next wave or finish
          wi <= wi + 1'b1;
          if (CNTB'(wi + 1'b1) == count) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && (action == ACT_EVAL)) begin
      gx   <= grid_x;
      gy   <= grid_y;
      hsum <= '0;
      xsum <= '0;
      ysum <= '0;
    end
    if (state == S_PREP) begin
      div_rem <= '0;
      div_quo <= {idx_len, 8'd0};
    end
    if (state == S_DIV) begin
      div_rem <= q_bit ? rem_diff[NW-1:0] : rem_sh[NW-1:0];
      div_quo <= q_final;
      if (32'(div_cnt) == DIV_W - 1) begin
        if (!axis) begin
          px <= pos_c;
        end else begin
          py <= pos_c;
        end
      end
    end
    if (state == S_MUL) begin
      m_hx <= ANG_W'(signed'(rd_data.hx)) * ANG_W'(px);
      m_hy <= ANG_W'(signed'(rd_data.hy)) * ANG_W'(py);
      wt   <= 28'(48'(rd_data.ktemp) * 48'(sim_time));
      qa   <= sq_amp[31:16];
    end
    if (state == S_DOT) begin
      dot  <= m_hx + m_hy;
      hq_x <= 33'(signed'(rd_data.hx)) * 33'(signed'({1'b0, qa}));
      hq_y <= 33'(signed'(rd_data.hy)) * 33'(signed'({1'b0, qa}));
    end
    if (state == S_ANG) begin
      ang_a <= ang_sum[ANG_W-1:26];
    end
    for (int l = 0; l < 2; l++) begin
      if (state == S_SQ) begin
        l_quad[l] <= lane_ang[l][15:14];
        l_r[l]    <= r_c[l];
        l_x2[l]   <= sq_c[l][28:14];
      end
      if (state == S_P1) begin
        l_u1[l] <= u1_c[l];
      end
      if (state == S_P2) begin
        l_u2[l] <= u2_c[l];
      end
      if (state == S_SIN) begin
        l_s[l] <= s_c[l];
      end
    end
    if (state == S_ACC) begin
      hsum <= hsum + HSW'(h_term);
      xsum <= xsum - XSW'(x_term);
      ysum <= ysum - XSW'(y_term);
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      height  <= h_sat;
      shift_x <= x_sat;
      shift_y <= y_sat;
    end
  end

  // Checks
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result shown without a finished evaluate");

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (action == ACT_EVAL)) |=> (state == S_PREP))
    else $error("evaluate request did not start the divider");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (wi < count))
    else $error("table read beyond the wave count");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !mem_we)
    else $error("table written during an evaluate");

endmodule
